@@ sv/bdl_pkg.sv @@
package bdl_pkg;

  // fixed geometry of the payload fields
  localparam int WORD_BITS       = 32;
  localparam int MAX_NEURONS_DEF = 64;
  localparam int MAX_WORDS_DEF   = 32;
  localparam int OP_W            = 2;
  localparam int NEURON_W        = 6;
  localparam int WIDX_W          = 5;
  localparam int BIAS_W          = 16;
  localparam int SUM_W           = 17;
  localparam int BITS_W          = $clog2(WORD_BITS + 1);

  // configuration register widths
  localparam int IW_W       = 6;
  localparam int OC_W       = 7;
  localparam int LB_W       = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // saturation limits of the result sum
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_WEIGHT = 2'd0,
    OP_BIAS   = 2'd1,
    OP_ACT    = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_WORDS  = 2'd0,
    CFG_OUTPUT_COUNT = 2'd1,
    CFG_LAST_BITS    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  // one neuron step, aligned with the memory read data
  typedef struct packed {
    logic                vld;
    logic                fin;
    logic                last;
    logic [NEURON_W-1:0] neuron;
  } issue_t;

  // activation word under work
  typedef struct packed {
    logic [WORD_BITS-1:0] data;
    logic [WORD_BITS-1:0] mask;
    logic [BITS_W-1:0]    bits;
  } item_t;

endpackage

@@ sv/bdl_ram.sv @@
module bdl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, data held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/bdl_ctrl.sv @@
module bdl_ctrl #(
  parameter int MAX_NEURONS = bdl_pkg::MAX_NEURONS_DEF,
  parameter int MAX_WORDS   = bdl_pkg::MAX_WORDS_DEF,
  parameter int WAW         = 11,
  parameter int NIW         = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bdl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bdl_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [bdl_pkg::OP_W-1:0]         op_i,
  input  logic [bdl_pkg::NEURON_W-1:0]     neuron_i,
  input  logic [bdl_pkg::WIDX_W-1:0]       widx_i,
  input  logic [bdl_pkg::WORD_BITS-1:0]    data_i,
  input  logic [bdl_pkg::BIAS_W-1:0]       bias_i,
  input  logic                             hold_i,
  output logic                             wram_we_o,
  output logic [WAW-1:0]                   wram_waddr_o,
  output logic [bdl_pkg::WORD_BITS-1:0]    wram_wdata_o,
  output logic                             bram_we_o,
  output logic [NIW-1:0]                   bram_waddr_o,
  output logic [bdl_pkg::BIAS_W-1:0]       bram_wdata_o,
  output logic                             rd_en_o,
  output logic [WAW-1:0]                   wram_raddr_o,
  output logic [NIW-1:0]                   nrn_raddr_o,
  output bdl_pkg::issue_t                  issue_o,
  output bdl_pkg::item_t                   item_o
);

  localparam int CW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int NCW = $clog2(MAX_NEURONS + 1);
  localparam int EW  = ((bdl_pkg::IW_W > $clog2(MAX_WORDS + 1)) ?
                        bdl_pkg::IW_W : $clog2(MAX_WORDS + 1)) + 1;

  bdl_pkg::state_e state_q, state_d;
  logic [bdl_pkg::IW_W-1:0] iw_q, iw_d;
  logic [bdl_pkg::OC_W-1:0] oc_q, oc_d;
  logic [bdl_pkg::LB_W-1:0] lb_q, lb_d;
  logic [CW-1:0]            word_cnt_q, word_cnt_d;
  logic [NIW-1:0]           jn_q, jn_d;
  logic [WAW-1:0]           waddr_q, waddr_d;
  logic [NCW-1:0]           count_q, count_d;
  logic                     fin_q, fin_d;
  bdl_pkg::issue_t          issue_q, issue_d;
  bdl_pkg::item_t           item_q, item_d;

  logic                     accept;
  logic [EW-1:0]            eff_words;
  logic [bdl_pkg::OC_W-1:0] eff_count;
  logic                     is_final;
  logic [bdl_pkg::BITS_W-1:0] bits;
  logic                     is_last;
  logic                     issue_go;

  // configuration registers
  always_comb begin
    iw_d = iw_q;
    oc_d = oc_q;
    lb_d = lb_q;
    if (cfg_we_i) begin
      case (bdl_pkg::cfg_idx_e'(cfg_idx_i))
        bdl_pkg::CFG_INPUT_WORDS:  iw_d = cfg_wdata_i[bdl_pkg::IW_W-1:0];
        bdl_pkg::CFG_OUTPUT_COUNT: oc_d = cfg_wdata_i[bdl_pkg::OC_W-1:0];
        bdl_pkg::CFG_LAST_BITS:    lb_d = cfg_wdata_i[bdl_pkg::LB_W-1:0];
        default: ;
      endcase
    end
  end

  // effective word and neuron counts
  always_comb begin
    if (iw_q == '0) begin
      eff_words = EW'(1);
    end else if (EW'(iw_q) > EW'(MAX_WORDS)) begin
      eff_words = EW'(MAX_WORDS);
    end else begin
      eff_words = EW'(iw_q);
    end
    if (oc_q == '0) begin
      eff_count = bdl_pkg::OC_W'(1);
    end else if (oc_q > bdl_pkg::OC_W'(MAX_NEURONS)) begin
      eff_count = bdl_pkg::OC_W'(MAX_NEURONS);
    end else begin
      eff_count = oc_q;
    end
  end

  assign is_final = (EW'(word_cnt_q) + EW'(1)) >= eff_words;
  assign bits     = (is_final && (lb_q != '0)) ? bdl_pkg::BITS_W'(lb_q) :
                                                 bdl_pkg::BITS_W'(bdl_pkg::WORD_BITS);

  // no transfer while the last neuron step still waits on the output register
  assign in_ready_o = (state_q == bdl_pkg::ST_IDLE) && !hold_i;
  assign accept     = in_valid_i && in_ready_o;
  assign issue_go   = (state_q == bdl_pkg::ST_RUN) && !hold_i;
  assign is_last    = (NCW'(jn_q) + NCW'(1)) == count_q;

  // store writes
  assign wram_waddr_o = WAW'(32'(neuron_i) * 32'(MAX_WORDS) + 32'(widx_i));
  assign wram_wdata_o = data_i;
  assign bram_waddr_o = NIW'(neuron_i);
  assign bram_wdata_o = bias_i;

  // reads for the neuron sweep
  assign rd_en_o      = issue_go;
  assign wram_raddr_o = waddr_q;
  assign nrn_raddr_o  = jn_q;

  // sequencer: next state and outputs
  always_comb begin
    state_d    = state_q;
    word_cnt_d = word_cnt_q;
    jn_d       = jn_q;
    waddr_d    = waddr_q;
    count_d    = count_q;
    fin_d      = fin_q;
    item_d     = item_q;
    wram_we_o  = 1'b0;
    bram_we_o  = 1'b0;
    issue_d    = issue_q;

    case (state_q)
      bdl_pkg::ST_IDLE: begin
        if (accept) begin
          case (bdl_pkg::op_e'(op_i))
            bdl_pkg::OP_WEIGHT: begin
              wram_we_o = (32'(neuron_i) < MAX_NEURONS) && (32'(widx_i) < MAX_WORDS);
            end
            bdl_pkg::OP_BIAS: begin
              bram_we_o = 32'(neuron_i) < MAX_NEURONS;
            end
            bdl_pkg::OP_ACT: begin
              item_d.data = data_i;
              item_d.mask = ~({bdl_pkg::WORD_BITS{1'b1}} << bits);
              item_d.bits = bits;
              fin_d       = is_final;
              count_d     = NCW'(eff_count);
              jn_d        = '0;
              waddr_d     = WAW'(word_cnt_q);
              word_cnt_d  = is_final ? '0 : word_cnt_q + CW'(1);
              state_d     = bdl_pkg::ST_RUN;
            end
            default: ;
          endcase
        end
      end
      bdl_pkg::ST_RUN: begin
        if (issue_go) begin
          jn_d    = jn_q + NIW'(1);
          waddr_d = waddr_q + WAW'(MAX_WORDS);
          if (is_last) begin
            state_d = bdl_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = bdl_pkg::ST_IDLE;
    endcase

    // step descriptor, frozen while the result stage waits
    if (!hold_i) begin
      issue_d.vld    = issue_go;
      issue_d.fin    = fin_q;
      issue_d.last   = is_last;
      issue_d.neuron = bdl_pkg::NEURON_W'(jn_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bdl_pkg::ST_IDLE;
      iw_q       <= bdl_pkg::IW_W'(32);
      oc_q       <= bdl_pkg::OC_W'(64);
      lb_q       <= '0;
      word_cnt_q <= '0;
      jn_q       <= '0;
      waddr_q    <= '0;
      count_q    <= '0;
      fin_q      <= 1'b0;
      issue_q    <= '0;
    end else begin
      state_q    <= state_d;
      iw_q       <= iw_d;
      oc_q       <= oc_d;
      lb_q       <= lb_d;
      word_cnt_q <= word_cnt_d;
      jn_q       <= jn_d;
      waddr_q    <= waddr_d;
      count_q    <= count_d;
      fin_q      <= fin_d;
      issue_q    <= issue_d;
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign issue_o = issue_q;
  assign item_o  = item_q;

`ifndef SYNTHESIS
  a_last_step_leaves_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_q.vld && issue_q.last |-> state_q == bdl_pkg::ST_IDLE)
    else $error("last neuron step issued while the sweep is still running");

  a_final_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (bdl_pkg::op_e'(op_i) == bdl_pkg::OP_ACT) && is_final |=> word_cnt_q == '0)
    else $error("word counter not cleared after the final word");

  a_no_store_write_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wram_we_o || bram_we_o) |-> !rd_en_o)
    else $error("store write overlaps a sweep read");
`endif

endmodule

@@ sv/bdl_mac.sv @@
module bdl_mac #(
  parameter int MAX_NEURONS = bdl_pkg::MAX_NEURONS_DEF,
  parameter int ACC_W       = 12,
  parameter int NIW         = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bdl_pkg::issue_t                issue_i,
  input  bdl_pkg::item_t                 item_i,
  input  logic [bdl_pkg::WORD_BITS-1:0]  wram_rdata_i,
  input  logic [bdl_pkg::BIAS_W-1:0]     bram_rdata_i,
  input  logic [ACC_W-1:0]               aram_rdata_i,
  output logic                           hold_o,
  output logic                           aram_we_o,
  output logic [NIW-1:0]                 aram_waddr_o,
  output logic [ACC_W-1:0]               aram_wdata_o,
  output logic                           m_valid_o,
  input  logic                           m_ready_i,
  output logic [bdl_pkg::NEURON_W-1:0]   m_index_o,
  output logic [bdl_pkg::SUM_W-1:0]      m_sum_o,
  output logic                           m_last_o
);

  localparam int TW    = bdl_pkg::BITS_W + 2;
  localparam int EXT_W = ((ACC_W > bdl_pkg::BIAS_W) ? ACC_W : bdl_pkg::BIAS_W) + 1;

  function automatic logic [bdl_pkg::BITS_W-1:0] popcount(
    input logic [bdl_pkg::WORD_BITS-1:0] v
  );
    logic [bdl_pkg::BITS_W-1:0] n;
    n = '0;
    for (int i = 0; i < bdl_pkg::WORD_BITS; i++) begin
      n = n + bdl_pkg::BITS_W'(v[i]);
    end
    return n;
  endfunction

  logic [MAX_NEURONS-1:0]            acc_vld_q, acc_vld_d;
  logic                              m_valid_q, m_valid_d;
  logic [bdl_pkg::NEURON_W-1:0]      m_index_q;
  logic signed [bdl_pkg::SUM_W-1:0]  m_sum_q;
  logic                              m_last_q;

  logic                              step;
  logic                              load;
  logic [NIW-1:0]                    nidx;
  logic [bdl_pkg::WORD_BITS-1:0]     agree;
  logic [bdl_pkg::BITS_W-1:0]        pc;
  logic signed [TW-1:0]              term;
  logic signed [ACC_W-1:0]           acc_old;
  logic signed [ACC_W-1:0]           acc_new;
  logic signed [EXT_W-1:0]           sum_ext;
  logic signed [bdl_pkg::SUM_W-1:0]  sum_sat;

  // a final-word step waits while the output register is full and not taken
  assign hold_o = issue_i.vld && issue_i.fin && m_valid_q && !m_ready_i;
  assign step   = issue_i.vld && !hold_o;
  assign load   = step && issue_i.fin;
  assign nidx   = issue_i.neuron[NIW-1:0];

  // xnor, popcount and the signed term 2*pc - bits
  assign agree = ~(item_i.data ^ wram_rdata_i) & item_i.mask;
  assign pc    = popcount(agree);
  assign term  = $signed({1'b0, pc, 1'b0}) - $signed({2'b00, item_i.bits});

  // accumulate, an entry without a valid flag reads as zero
  assign acc_old = acc_vld_q[nidx] ? $signed(aram_rdata_i) : '0;
  assign acc_new = acc_old + ACC_W'(term);

  // add bias and saturate
  always_comb begin
    sum_ext = EXT_W'(acc_new) + EXT_W'($signed(bram_rdata_i));
    if (sum_ext > EXT_W'(bdl_pkg::SUM_MAX)) begin
      sum_sat = bdl_pkg::SUM_MAX;
    end else if (sum_ext < EXT_W'(bdl_pkg::SUM_MIN)) begin
      sum_sat = bdl_pkg::SUM_MIN;
    end else begin
      sum_sat = bdl_pkg::SUM_W'(sum_ext);
    end
  end

  // write back on ordinary words
  assign aram_we_o    = step && !issue_i.fin;
  assign aram_waddr_o = nidx;
  assign aram_wdata_o = acc_new;

  // valid flags, all dropped once the final sweep completes
  always_comb begin
    acc_vld_d = acc_vld_q;
    if (aram_we_o) begin
      acc_vld_d[nidx] = 1'b1;
    end
    if (load && issue_i.last) begin
      acc_vld_d = '0;
    end
  end

  assign m_valid_d = load || (m_valid_q && !m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      acc_vld_q <= acc_vld_d;
      m_valid_q <= m_valid_d;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      m_index_q <= issue_i.neuron;
      m_sum_q   <= sum_sat;
      m_last_q  <= issue_i.last;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_index_o = m_index_q;
  assign m_sum_o   = m_sum_q;
  assign m_last_o  = m_last_q;

`ifndef SYNTHESIS
  a_flags_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && issue_i.last |=> acc_vld_q == '0)
    else $error("accumulator flags survive the end of a vector");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> m_valid_q && (m_index_q == $past(issue_i.neuron)))
    else $error("finished neuron did not reach the output register");
`endif

endmodule

@@ sv/binary_dense_layer_xnor_popcount.sv @@
// Binary fully connected layer with xnor-popcount accumulation.
// Input stream (s_axis): one transfer per item. Weight and bias loads write
// their memories. An activation word sweeps the active neurons, one neuron
// per cycle while the sweep is not paused (see Stall), through the weight,
// bias and accumulator memories; the next item is taken only after the
// sweep ends.
// Output stream (m_axis): after the final word of a vector one transfer per
// active neuron leaves in neuron order, one per cycle while m_axis_tready
// stays high; tlast marks the highest active neuron.
// Configuration: cfg_we_i writes register cfg_idx_i (0 input_words,
// 1 output_count, 2 last_bits).
// Reset: registers return to 32 words, 64 neurons, full final word; the
// accumulators read as zero at once, weight and bias memories hold nothing
// defined until loaded.
// Stall: a result held in the output register pauses the sweep of a final
// word; no transfer is lost and input is not taken until the sweep ends.
module binary_dense_layer_xnor_popcount #(
  parameter int MAX_NEURONS = bdl_pkg::MAX_NEURONS_DEF,
  parameter int MAX_WORDS   = bdl_pkg::MAX_WORDS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bdl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bdl_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // neuron, word_index, data_word, bias_value, zero pad
  input  logic [63:0]                    s_axis_tdata,
  // operation
  input  logic [bdl_pkg::OP_W-1:0]       s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // neuron_index, neuron_sum, zero pad
  output logic [23:0]                    m_axis_tdata,
  output logic                           m_axis_tlast
);

  localparam int WDEPTH = MAX_NEURONS * MAX_WORDS;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int NIW    = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
  localparam int ACC_W  = $clog2(MAX_WORDS * bdl_pkg::WORD_BITS + 1) + 1;

  logic [bdl_pkg::OP_W-1:0]       op;
  logic [bdl_pkg::NEURON_W-1:0]   neuron;
  logic [bdl_pkg::WIDX_W-1:0]     widx;
  logic [bdl_pkg::WORD_BITS-1:0]  data;
  logic [bdl_pkg::BIAS_W-1:0]     bias;

  logic                           wram_we;
  logic [WAW-1:0]                 wram_waddr;
  logic [bdl_pkg::WORD_BITS-1:0]  wram_wdata;
  logic                           bram_we;
  logic [NIW-1:0]                 bram_waddr;
  logic [bdl_pkg::BIAS_W-1:0]     bram_wdata;
  logic                           rd_en;
  logic [WAW-1:0]                 wram_raddr;
  logic [NIW-1:0]                 nrn_raddr;
  logic [bdl_pkg::WORD_BITS-1:0]  wram_rdata;
  logic [bdl_pkg::BIAS_W-1:0]     bram_rdata;
  logic [ACC_W-1:0]               aram_rdata;
  logic                           aram_we;
  logic [NIW-1:0]                 aram_waddr;
  logic [ACC_W-1:0]               aram_wdata;
  logic                           hold;
  bdl_pkg::issue_t                issue;
  bdl_pkg::item_t                 item;
  logic [bdl_pkg::NEURON_W-1:0]   m_index;
  logic [bdl_pkg::SUM_W-1:0]      m_sum;

  // unpack the input transfer
  assign op     = s_axis_tuser;
  assign neuron = s_axis_tdata[5:0];
  assign widx   = s_axis_tdata[10:6];
  assign data   = s_axis_tdata[42:11];
  assign bias   = s_axis_tdata[58:43];

  // sequencer and configuration
  bdl_ctrl #(
    .MAX_NEURONS (MAX_NEURONS),
    .MAX_WORDS   (MAX_WORDS),
    .WAW         (WAW),
    .NIW         (NIW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .op_i         (op),
    .neuron_i     (neuron),
    .widx_i       (widx),
    .data_i       (data),
    .bias_i       (bias),
    .hold_i       (hold),
    .wram_we_o    (wram_we),
    .wram_waddr_o (wram_waddr),
    .wram_wdata_o (wram_wdata),
    .bram_we_o    (bram_we),
    .bram_waddr_o (bram_waddr),
    .bram_wdata_o (bram_wdata),
    .rd_en_o      (rd_en),
    .wram_raddr_o (wram_raddr),
    .nrn_raddr_o  (nrn_raddr),
    .issue_o      (issue),
    .item_o       (item)
  );

  // weight words, one row of words per neuron
  bdl_ram #(
    .WIDTH (bdl_pkg::WORD_BITS),
    .DEPTH (WDEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (wram_we),
    .waddr_i (wram_waddr),
    .wdata_i (wram_wdata),
    .re_i    (rd_en),
    .raddr_i (wram_raddr),
    .rdata_o (wram_rdata)
  );

  // biases
  bdl_ram #(
    .WIDTH (bdl_pkg::BIAS_W),
    .DEPTH (MAX_NEURONS)
  ) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (bram_we),
    .waddr_i (bram_waddr),
    .wdata_i (bram_wdata),
    .re_i    (rd_en),
    .raddr_i (nrn_raddr),
    .rdata_o (bram_rdata)
  );

  // accumulators
  bdl_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_NEURONS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (aram_we),
    .waddr_i (aram_waddr),
    .wdata_i (aram_wdata),
    .re_i    (rd_en),
    .raddr_i (nrn_raddr),
    .rdata_o (aram_rdata)
  );

  // popcount, accumulate and result register
  bdl_mac #(
    .MAX_NEURONS (MAX_NEURONS),
    .ACC_W       (ACC_W),
    .NIW         (NIW)
  ) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .issue_i      (issue),
    .item_i       (item),
    .wram_rdata_i (wram_rdata),
    .bram_rdata_i (bram_rdata),
    .aram_rdata_i (aram_rdata),
    .hold_o       (hold),
    .aram_we_o    (aram_we),
    .aram_waddr_o (aram_waddr),
    .aram_wdata_o (aram_wdata),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_index_o    (m_index),
    .m_sum_o      (m_sum),
    .m_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, m_sum, m_index};

endmodule
